### sv/gs_pkg.sv
// ----------------------------------------------------------------------------
// gs_pkg
// Shared types, codes and helpers of the Gauss-Seidel solver.
// ----------------------------------------------------------------------------
package gs_pkg;

    localparam int MAX_UNKNOWNS = 16;
    localparam int IDX_W        = $clog2(MAX_UNKNOWNS);
    localparam int CNT_W        = $clog2(MAX_UNKNOWNS + 1);
    localparam int ADDR_W       = 2 * IDX_W;
    localparam int COEF_DEPTH   = MAX_UNKNOWNS * MAX_UNKNOWNS;
    localparam int ACC_W        = 48 + CNT_W;
    localparam int DIVN_W       = 48;
    localparam int CQ_DEPTH     = 4;
    localparam int CQ_PTR_W     = $clog2(CQ_DEPTH);

    // input modes
    localparam logic [1:0] MODE_LOAD_A = 2'd0;
    localparam logic [1:0] MODE_LOAD_B = 2'd1;
    localparam logic [1:0] MODE_START  = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_DIAG  = 2'd1;
    localparam logic [1:0] STAT_LIMIT = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_SIZE  = 2'd0;
    localparam logic [1:0] REG_TOL   = 2'd1;
    localparam logic [1:0] REG_MAXIT = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic [3:0]         row;
        logic [3:0]         col;
        logic signed [31:0] value;
    } gs_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [3:0]         index;
        logic signed [31:0] solution;
        logic [15:0]        sweeps;
        logic               last;
    } gs_out_t;

    typedef enum logic [1:0] {
        CMD_LOAD_A,
        CMD_LOAD_B,
        CMD_START
    } gs_kind_t;

    typedef struct packed {
        gs_kind_t           kind;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic signed [31:0] value;
    } gs_cmd_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  index;
        logic [31:0] data;
    } gs_cfg_wr_t;

    typedef struct packed {
        logic               start;
        logic               num_neg;
        logic [DIVN_W-1:0]  num_mag;
        logic signed [31:0] den;
    } gs_div_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] quo;
    } gs_div_rsp_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DIAG_RD,
        S_DIAG_CHK,
        S_NRM_DRD,
        S_NRM_DGET,
        S_NRM_RD,
        S_NRM_DIV,
        S_NRM_WAIT,
        S_NRM_RHS,
        S_NRM_RWAIT,
        S_SW_INIT,
        S_SW_RD,
        S_SW_MUL,
        S_SW_ACC,
        S_SW_WR,
        S_DN_SQ,
        S_DN_ADD,
        S_DECIDE,
        S_EMIT
    } gs_state_t;

    function automatic logic signed [31:0] sat_acc(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(32'sh7FFF_FFFF);
        lo = -ACC_W'(33'sh0_8000_0000);
        if (v > hi)
            return 32'sh7FFF_FFFF;
        else if (v < lo)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

endpackage

### sv/gauss_seidel_solver.sv
// ----------------------------------------------------------------------------
// gauss_seidel_solver
// Q16.16 Gauss-Seidel solver: front end queues commands, engine solves.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  input     push / full               item   (mode, row, col, value)
//  result    empty / pop               result (status, index, solution, ...)
//  config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
//  Loads stream at one per cycle while the engine is idle and the queue is not full.
//  A solve runs the diagonal check, then n*(n-1)+n divisions (one quotient bit a
//  cycle), then the sweeps, then n results on success or one on failure.
//  Reset clears queues and state; the coefficient store holds no reset value.
//  Loads behind a start wait in the command queue; full rises when it fills.
// ----------------------------------------------------------------------------
module gauss_seidel_solver (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  gs_pkg::gs_in_t  item,
    output logic            empty,
    input  logic            pop,
    output gs_pkg::gs_out_t result,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [1:0]      cfg_index,
    input  logic [31:0]     cfg_data
);
    import gs_pkg::*;

    gs_cmd_t    cmd;
    logic       cmd_valid;
    logic       cmd_ready;
    gs_cfg_wr_t cfg;

    assign cfg_ready  = 1'b1;
    assign cfg.valid  = cfg_valid;
    assign cfg.index  = cfg_index;
    assign cfg.data   = cfg_data;

    gs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    gs_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

### sv/gs_front.sv
// ----------------------------------------------------------------------------
// gs_front
// Accepts input items, drops unused ones and queues commands for the engine.
// ----------------------------------------------------------------------------
module gs_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  gs_pkg::gs_in_t  item,
    output logic            cmd_valid,
    input  logic            cmd_ready,
    output gs_pkg::gs_cmd_t cmd
);
    import gs_pkg::*;

    gs_cmd_t               q_mem [CQ_DEPTH];
    logic [CQ_PTR_W-1:0]   wptr_reg, wptr_next;
    logic [CQ_PTR_W-1:0]   rptr_reg, rptr_next;
    logic [CQ_PTR_W:0]     cnt_reg, cnt_next;
    logic                  keep;
    logic                  wr_en;
    logic                  rd_en;
    gs_cmd_t               cls;

    // classify
    always_comb
    begin
        keep       = 1'b0;
        cls.kind   = CMD_LOAD_A;
        cls.row    = IDX_W'(item.row);
        cls.col    = IDX_W'(item.col);
        cls.value  = item.value;
        case (item.mode)
            MODE_LOAD_A:
            begin
                cls.kind = CMD_LOAD_A;
                keep = (32'(item.row) < MAX_UNKNOWNS) && (32'(item.col) < MAX_UNKNOWNS);
            end
            MODE_LOAD_B:
            begin
                cls.kind = CMD_LOAD_B;
                keep = 32'(item.row) < MAX_UNKNOWNS;
            end
            MODE_START:
            begin
                cls.kind = CMD_START;
                keep = 1'b1;
            end
            default: keep = 1'b0;
        endcase
    end

    assign full      = (cnt_reg == (CQ_PTR_W+1)'(CQ_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_mem[rptr_reg];
    assign wr_en     = push && !full && keep;
    assign rd_en     = cmd_valid && cmd_ready;

    always_comb
    begin
        wptr_next = wr_en ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = rd_en ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg + (CQ_PTR_W+1)'(wr_en) - (CQ_PTR_W+1)'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            q_mem[wptr_reg] <= cls;
    end

endmodule

### sv/gs_divider.sv
// ----------------------------------------------------------------------------
// gs_divider
// Radix-2 restoring divider, one quotient bit per cycle, saturating result.
// ----------------------------------------------------------------------------
module gs_divider (
    input  logic                clk,
    input  logic                rst_n,
    input  gs_pkg::gs_div_req_t req,
    output gs_pkg::gs_div_rsp_t rsp
);
    import gs_pkg::*;

    localparam int STEP_W = $clog2(DIVN_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [32:0]       rem_reg;
    logic [DIVN_W-1:0] q_reg;
    logic [31:0]       dmag_reg;
    logic              neg_reg;
    logic [32:0]       rem_sh;
    logic              ge;
    logic [31:0]       dmag_in;

    assign dmag_in = req.den[31] ? 32'(-req.den) : 32'(req.den);
    assign rem_sh  = {rem_reg[31:0], q_reg[DIVN_W-1]};
    assign ge      = rem_sh >= {1'b0, dmag_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(DIVN_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= '0;
            q_reg    <= req.num_mag;
            dmag_reg <= dmag_in;
            neg_reg  <= req.num_neg ^ req.den[31];
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_sh - {1'b0, dmag_reg} : rem_sh;
            q_reg   <= {q_reg[DIVN_W-2:0], ge};
        end
    end

    always_comb
    begin
        rsp.done = done_reg;
        if (!neg_reg)
            rsp.quo = (q_reg > DIVN_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(q_reg[31:0]);
        else
            rsp.quo = (q_reg > DIVN_W'(33'h0_8000_0000)) ? 32'sh8000_0000
                                                           : $signed(-q_reg[31:0]);
    end

endmodule

### sv/gs_engine.sv
// ----------------------------------------------------------------------------
// gs_engine
// Back end: matrix store, normalization, sweeps and the result queue.
// ----------------------------------------------------------------------------
module gs_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  gs_pkg::gs_cfg_wr_t cfg,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  gs_pkg::gs_cmd_t    cmd,
    output logic               empty,
    input  logic               pop,
    output gs_pkg::gs_out_t    result
);
    import gs_pkg::*;

    localparam int OQ_PTR_W = (MAX_UNKNOWNS > 1) ? $clog2(MAX_UNKNOWNS) : 1;

    gs_state_t state_reg, state_next;

    // configuration
    logic [4:0]  size_reg;
    logic [30:0] tol_reg;
    logic [15:0] maxit_reg;

    // stores
    logic signed [31:0] coef_mem [COEF_DEPTH];
    logic signed [31:0] coef_q;
    logic signed [31:0] rhs_arr    [MAX_UNKNOWNS];
    logic signed [31:0] scaled_arr [MAX_UNKNOWNS];
    logic signed [31:0] cur_x      [MAX_UNKNOWNS];
    logic signed [31:0] prev_x     [MAX_UNKNOWNS];

    // working registers
    logic [CNT_W-1:0]   n_reg;
    logic [IDX_W-1:0]   i_reg;
    logic [IDX_W-1:0]   j_reg;
    logic [15:0]        k_reg;
    logic [15:0]        limit_reg;
    logic [63:0]        tol2_reg;
    logic [63:0]        norm_reg;
    logic signed [31:0] d_reg;
    logic signed [31:0] xq_reg;
    logic signed [63:0] prod_reg;
    logic [63:0]        sq_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [1:0]         res_stat_reg;

    // control
    logic               coef_we;
    logic [ADDR_W-1:0]  coef_waddr;
    logic signed [31:0] coef_wdata;
    logic [ADDR_W-1:0]  coef_raddr;
    logic               i_last, j_last, diag_bad;
    logic [32:0]        diag_mag;
    gs_div_req_t        div_req;
    gs_div_rsp_t        div_rsp;
    logic [31:0]        num_abs;
    logic signed [31:0] num_src;

    // output queue
    gs_out_t             oq_mem [MAX_UNKNOWNS];
    logic [OQ_PTR_W-1:0] oq_wptr_reg, oq_rptr_reg;
    logic [CNT_W-1:0]    oq_cnt_reg;
    logic                oq_full, oq_push, oq_pop;
    gs_out_t             oq_in;

    logic [CNT_W-1:0]    n_eff;
    logic [32:0]         df;
    logic [31:0]         df_mag;
    logic [64:0]         norm_sum;

    assign i_last   = ({1'b0, i_reg} == (IDX_W+1)'(n_reg - 1'b1));
    assign j_last   = ({1'b0, j_reg} == (IDX_W+1)'(n_reg - 1'b1));
    assign diag_mag = coef_q[31] ? 33'(-{coef_q[31], coef_q}) : 33'({coef_q[31], coef_q});
    assign diag_bad = (coef_q == 0) || (diag_mag < {2'b00, tol_reg});

    always_comb
    begin
        if (size_reg == 5'd0)
            n_eff = CNT_W'(1);
        else if (32'(size_reg) > MAX_UNKNOWNS)
            n_eff = CNT_W'(MAX_UNKNOWNS);
        else
            n_eff = CNT_W'(size_reg);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:      if (cmd_valid && cmd.kind == CMD_START) state_next = S_DIAG_RD;
            S_DIAG_RD:   state_next = S_DIAG_CHK;
            S_DIAG_CHK:
            begin
                if (diag_bad)
                    state_next = S_EMIT;
                else if (i_last)
                    state_next = S_NRM_DRD;
                else
                    state_next = S_DIAG_RD;
            end
            S_NRM_DRD:   state_next = S_NRM_DGET;
            S_NRM_DGET:  state_next = S_NRM_RD;
            S_NRM_RD:
            begin
                if (j_reg != i_reg)
                    state_next = S_NRM_DIV;
                else if (j_last)
                    state_next = S_NRM_RHS;
            end
            S_NRM_DIV:   state_next = S_NRM_WAIT;
            S_NRM_WAIT:  if (div_rsp.done) state_next = j_last ? S_NRM_RHS : S_NRM_RD;
            S_NRM_RHS:   state_next = S_NRM_RWAIT;
            S_NRM_RWAIT: if (div_rsp.done) state_next = i_last ? S_SW_INIT : S_NRM_DRD;
            S_SW_INIT:   state_next = S_SW_RD;
            S_SW_RD:     state_next = S_SW_MUL;
            S_SW_MUL:    state_next = S_SW_ACC;
            S_SW_ACC:    state_next = j_last ? S_SW_WR : S_SW_RD;
            S_SW_WR:     state_next = i_last ? S_DN_SQ : S_SW_INIT;
            S_DN_SQ:     state_next = S_DN_ADD;
            S_DN_ADD:    state_next = i_last ? S_DECIDE : S_DN_SQ;
            S_DECIDE:
            begin
                if (norm_reg < tol2_reg || k_reg >= limit_reg)
                    state_next = S_EMIT;
                else
                    state_next = S_SW_INIT;
            end
            S_EMIT:
            begin
                if (!oq_full && (res_stat_reg != STAT_OK || i_last))
                    state_next = S_IDLE;
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        cmd_ready  = (state_reg == S_IDLE);
        coef_we    = 1'b0;
        coef_waddr = {i_reg, j_reg};
        coef_wdata = div_rsp.quo;
        coef_raddr = {i_reg, j_reg};
        num_src    = coef_q;
        div_req.start   = 1'b0;
        div_req.den     = d_reg;
        div_req.num_neg = !coef_q[31];
        oq_push    = 1'b0;
        oq_in.status   = res_stat_reg;
        oq_in.index    = 4'd0;
        oq_in.solution = 32'sd0;
        oq_in.sweeps   = k_reg;
        oq_in.last     = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                coef_we    = cmd_valid && cmd.kind == CMD_LOAD_A;
                coef_waddr = {cmd.row, cmd.col};
                coef_wdata = cmd.value;
            end
            S_DIAG_RD, S_NRM_DRD: coef_raddr = {i_reg, i_reg};
            S_NRM_DIV:  div_req.start = 1'b1;
            S_NRM_WAIT: coef_we = div_rsp.done;
            S_NRM_RHS:
            begin
                div_req.start   = 1'b1;
                num_src         = rhs_arr[i_reg];
                div_req.num_neg = rhs_arr[i_reg][31];
                coef_we         = 1'b1;
                coef_waddr      = {i_reg, i_reg};
                coef_wdata      = 32'sd0;
            end
            S_EMIT:
            begin
                oq_push = !oq_full;
                if (res_stat_reg == STAT_OK)
                begin
                    oq_in.index    = 4'(i_reg);
                    oq_in.solution = cur_x[i_reg];
                    oq_in.last     = i_last;
                end
                else if (res_stat_reg == STAT_DIAG)
                    oq_in.sweeps = 16'd0;
            end
            default: ;
        endcase
        num_abs         = num_src[31] ? 32'(-num_src) : 32'(num_src);
        div_req.num_mag = DIVN_W'({num_abs, 16'h0000});
    end

    gs_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // coefficient memory
    always_ff @(posedge clk)
    begin
        if (coef_we)
            coef_mem[coef_waddr] <= coef_wdata;
        coef_q <= coef_mem[coef_raddr];
    end

    assign df       = 33'({cur_x[i_reg][31], cur_x[i_reg]} - {prev_x[i_reg][31], prev_x[i_reg]});
    assign df_mag   = df[32] ? 32'(-df) : df[31:0];
    assign norm_sum = {1'b0, norm_reg} + {1'b0, sq_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            size_reg  <= 5'd16;
            tol_reg   <= 31'd65;
            maxit_reg <= 16'd100;
            for (int e = 0; e < MAX_UNKNOWNS; e++)
            begin
                cur_x[e]  <= 32'sd0;
                prev_x[e] <= 32'sd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_SIZE:  size_reg  <= cfg.data[4:0];
                    REG_TOL:   tol_reg   <= cfg.data[30:0];
                    REG_MAXIT: maxit_reg <= cfg.data[15:0];
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid && cmd.kind == CMD_START)
                    begin
                        for (int e = 0; e < MAX_UNKNOWNS; e++)
                        begin
                            cur_x[e]  <= 32'sd0;
                            prev_x[e] <= 32'sd0;
                        end
                    end
                end
                S_SW_WR: cur_x[i_reg] <= sat_acc(acc_reg);
                S_DN_SQ: prev_x[i_reg] <= cur_x[i_reg];
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && cmd.kind == CMD_LOAD_B)
                    rhs_arr[cmd.row] <= cmd.value;
                n_reg        <= n_eff;
                limit_reg    <= (maxit_reg == 16'd0) ? 16'd1 : maxit_reg;
                tol2_reg     <= 64'(tol_reg) * 64'(tol_reg);
                i_reg        <= '0;
                j_reg        <= '0;
                k_reg        <= 16'd1;
                res_stat_reg <= STAT_DIAG;
            end
            S_DIAG_CHK:
            begin
                if (!diag_bad)
                    i_reg <= i_last ? '0 : i_reg + 1'b1;
            end
            S_NRM_DGET:
            begin
                d_reg <= coef_q;
                j_reg <= '0;
            end
            S_NRM_RD:
            begin
                if (j_reg == i_reg && !j_last)
                    j_reg <= j_reg + 1'b1;
            end
            S_NRM_WAIT:
            begin
                if (div_rsp.done && !j_last)
                    j_reg <= j_reg + 1'b1;
            end
            S_NRM_RWAIT:
            begin
                if (div_rsp.done)
                begin
                    scaled_arr[i_reg] <= div_rsp.quo;
                    i_reg <= i_last ? '0 : i_reg + 1'b1;
                end
            end
            S_SW_INIT:
            begin
                acc_reg <= ACC_W'(scaled_arr[i_reg]);
                j_reg   <= '0;
            end
            S_SW_RD:  xq_reg   <= cur_x[j_reg];
            S_SW_MUL: prod_reg <= coef_q * xq_reg;
            S_SW_ACC:
            begin
                // floor to Q16.16
                acc_reg <= acc_reg + ACC_W'(prod_reg >>> 16);
                if (!j_last)
                    j_reg <= j_reg + 1'b1;
            end
            S_SW_WR:
            begin
                i_reg <= i_last ? '0 : i_reg + 1'b1;
                if (i_last)
                    norm_reg <= 64'd0;
            end
            S_DN_SQ: sq_reg <= 64'(df_mag) * 64'(df_mag);
            S_DN_ADD:
            begin
                norm_reg <= norm_sum[64] ? {64{1'b1}} : norm_sum[63:0];
                i_reg    <= i_last ? '0 : i_reg + 1'b1;
            end
            S_DECIDE:
            begin
                i_reg <= '0;
                if (norm_reg < tol2_reg)
                    res_stat_reg <= STAT_OK;
                else if (k_reg >= limit_reg)
                    res_stat_reg <= STAT_LIMIT;
                else
                    k_reg <= k_reg + 1'b1;
            end
            S_EMIT:
            begin
                if (!oq_full)
                    i_reg <= i_reg + 1'b1;
            end
            default: ;
        endcase
    end

    // result queue
    assign oq_full = (oq_cnt_reg == CNT_W'(MAX_UNKNOWNS));
    assign empty   = (oq_cnt_reg == '0);
    assign oq_pop  = pop && !empty;
    assign result  = oq_mem[oq_rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wptr_reg <= '0;
            oq_rptr_reg <= '0;
            oq_cnt_reg  <= '0;
        end
        else
        begin
            if (oq_push)
                oq_wptr_reg <= (oq_wptr_reg == OQ_PTR_W'(MAX_UNKNOWNS - 1)) ? '0
                                                                           : oq_wptr_reg + 1'b1;
            if (oq_pop)
                oq_rptr_reg <= (oq_rptr_reg == OQ_PTR_W'(MAX_UNKNOWNS - 1)) ? '0
                                                                           : oq_rptr_reg + 1'b1;
            oq_cnt_reg <= oq_cnt_reg + CNT_W'(oq_push) - CNT_W'(oq_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_push)
            oq_mem[oq_wptr_reg] <= oq_in;
    end

endmodule

### sv/gs_checker.sv
// ----------------------------------------------------------------------------
// gs_checker
// Port-level checks of the solver's result stream.
// ----------------------------------------------------------------------------
module gs_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            empty,
    input logic            pop,
    input gs_pkg::gs_out_t result
);
    import gs_pkg::*;

    // failures carry no solution
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.status != STAT_OK) |->
            (result.last && result.index == 4'd0 && result.solution == 32'sd0))
        else $error("failure transaction carries data");

    a_diag_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.status == STAT_DIAG) |-> (result.sweeps == 16'd0))
        else $error("small diagonal with nonzero sweeps");

    a_limit_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.status == STAT_LIMIT) |-> (result.sweeps != 16'd0))
        else $error("iteration limit with zero sweeps");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting transaction changed");

endmodule

bind gauss_seidel_solver gs_checker u_gs_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

### tb/tb_gauss_seidel_solver.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gauss_seidel_solver
// Self-checking bench for the Q16.16 Gauss-Seidel solver. Drives matrix and
// rhs loads, then solve commands, through the push/full queue. A scoreboard
// predicts every result (diagonal check, row normalization, sweeps) and
// compares them field by field as they are popped. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb_gauss_seidel_solver;
    import gs_pkg::*;

    localparam int          SETTLE_CYCLES = 32;
    localparam int          ITEM_TARGET   = 120;
    localparam logic [1:0]  MODE_UNUSED   = 2'd3;
    localparam longint      SAT_HI        = 64'sd2147483647;
    localparam longint      SAT_LO        = -64'sd2147483648;

    typedef enum {SYS_DOMINANT, SYS_WEAK_DIAG, SYS_WILD} sys_shape_t;

    class solve_scoreboard;
        logic signed [31:0] coef [MAX_UNKNOWNS][MAX_UNKNOWNS];
        logic signed [31:0] rhs_vec [MAX_UNKNOWNS];
        logic signed [31:0] scaled [MAX_UNKNOWNS];
        logic signed [31:0] x_now [MAX_UNKNOWNS];
        logic signed [31:0] x_prev [MAX_UNKNOWNS];
        logic [4:0]         size_reg  = 5'd16;
        logic [30:0]        tol_reg   = 31'd65;
        logic [15:0]        maxit_reg = 16'd100;
        gs_out_t            expected_results[$];
        int                 errors;

        function void write_reg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                REG_SIZE:  size_reg  = data[4:0];
                REG_TOL:   tol_reg   = data[30:0];
                REG_MAXIT: maxit_reg = data[15:0];
                default: ;
            endcase
        endfunction

        function logic signed [31:0] sat32(longint v);
            if (v > SAT_HI)
                return 32'sh7FFF_FFFF;
            if (v < SAT_LO)
                return 32'sh8000_0000;
            return v[31:0];
        endfunction

        function logic signed [31:0] fx_div(longint num, logic signed [31:0] den);
            return sat32((num * 65536) / longint'(den));
        endfunction

        function void add_result(logic [1:0] st, int idx, logic signed [31:0] sol,
                                 int sw, bit lst);
            gs_out_t r;
            r.status   = st;
            r.index    = idx[3:0];
            r.solution = sol;
            r.sweeps   = sw[15:0];
            r.last     = lst;
            expected_results.push_back(r);
        endfunction

        function void solve_system();
            int              n;
            int              lim;
            int              k;
            longint          d;
            longint          acc;
            longint          df;
            longint unsigned m;
            longint unsigned sq;
            longint unsigned norm;
            longint unsigned tol2;
            logic signed [31:0] dg;
            n   = (size_reg == 0) ? 1 : ((size_reg > MAX_UNKNOWNS) ? MAX_UNKNOWNS : size_reg);
            lim = (maxit_reg == 0) ? 1 : maxit_reg;
            for (int i = 0; i < n; i++) begin
                d = longint'(coef[i][i]);
                if (d == 0 || (d < 0 ? -d : d) < longint'(tol_reg)) begin
                    add_result(STAT_DIAG, 0, 0, 0, 1'b1);
                    return;
                end
            end
            for (int i = 0; i < n; i++) begin
                dg = coef[i][i];
                for (int j = 0; j < n; j++)
                    if (j != i)
                        coef[i][j] = fx_div(-longint'(coef[i][j]), dg);
                coef[i][i] = 0;
                scaled[i] = fx_div(longint'(rhs_vec[i]), dg);
            end
            for (int i = 0; i < MAX_UNKNOWNS; i++) begin
                x_now[i]  = 0;
                x_prev[i] = 0;
            end
            tol2 = longint'(tol_reg) * longint'(tol_reg);
            k = 0;
            forever begin
                k++;
                norm = 0;
                for (int i = 0; i < n; i++) begin
                    acc = longint'(scaled[i]);
                    for (int j = 0; j < n; j++)
                        if (j != i)
                            acc += (longint'(coef[i][j]) * longint'(x_now[j])) >>> 16;
                    x_now[i] = sat32(acc);
                end
                for (int i = 0; i < n; i++) begin
                    df = longint'(x_now[i]) - longint'(x_prev[i]);
                    m  = (df < 0) ? -df : df;
                    if (m >= 64'h1_0000_0000) begin
                        norm = '1;
                    end
                    else begin
                        sq   = m * m;
                        norm = (norm > ~64'd0 - sq) ? '1 : norm + sq;
                    end
                end
                if (norm < tol2) begin
                    for (int i = 0; i < n; i++)
                        add_result(STAT_OK, i, x_now[i], k, i + 1 == n);
                    return;
                end
                if (k >= lim) begin
                    add_result(STAT_LIMIT, 0, 0, k, 1'b1);
                    return;
                end
                x_prev = x_now;
            end
        endfunction

        function void note_item(gs_in_t it);
            case (it.mode)
                MODE_LOAD_A: coef[it.row][it.col] = it.value;
                MODE_LOAD_B: rhs_vec[it.row] = it.value;
                MODE_START:  solve_system();
                default: ;
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(gs_out_t got);
            gs_out_t want;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected, expected none actual %0h",
                         $time, got);
                return;
            end
            want = expected_results.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("index", 32'(want.index), 32'(got.index));
            compare_field("solution", 32'(want.solution), 32'(got.solution));
            compare_field("sweeps", 32'(want.sweeps), 32'(got.sweeps));
            compare_field("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        push      = 1'b0;
    logic        full;
    gs_in_t      item      = '0;
    logic        empty;
    logic        pop       = 1'b0;
    gs_out_t     result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_SIZE;
    logic [31:0] cfg_data  = '0;

    bit              quiet;
    int              items_sent;
    solve_scoreboard sb = new();

    gauss_seidel_solver DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit idle_roll();
        return !quiet && ($urandom_range(99) < 24);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (push && !full)
                sb.note_item(item);
            if (pop && !empty)
                sb.check_result(result);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
            pop <= !idle_roll();
    end

    // push stays high after a transaction; the next send or wait_idle decides
    task automatic send_cmd(input logic [1:0] mode, input int r,
                            input int c, input logic [31:0] v);
        gs_in_t it;
        it.mode  = mode;
        it.row   = r[3:0];
        it.col   = c[3:0];
        it.value = v;
        while (idle_roll()) begin
            push <= 1'b0;
            @(posedge clk);
        end
        item <= it;
        push <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (mode != MODE_UNUSED)
            items_sent++;
    endtask

    task automatic write_regs(input logic [31:0] sz, input logic [31:0] tl,
                              input logic [31:0] mi);
        logic [1:0]  idx [3];
        logic [31:0] vals [3];
        idx  = '{REG_SIZE, REG_TOL, REG_MAXIT};
        vals = '{sz, tl, mi};
        for (int i = 0; i < 3; i++) begin
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            cfg_valid <= 1'b1;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            sb.write_reg(idx[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // let queued loads drain as well, since they produce no result
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge clk);
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_system(input int n, input sys_shape_t shape);
        int                 weak_row;
        logic signed [31:0] v;
        weak_row = $urandom_range(n - 1);
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
                if (shape == SYS_WILD) begin
                    v = $urandom;
                end
                else if (r == c) begin
                    v = (n + 1) * 65536 + $urandom_range(65535);
                    if (shape == SYS_WEAK_DIAG && r == weak_row)
                        v = (sb.tol_reg == 0) ? 0 : $urandom_range(sb.tol_reg - 1);
                    if ($urandom_range(1))
                        v = -v;
                end
                else begin
                    v = $signed($urandom_range(131070)) - 65535;
                end
                send_cmd(MODE_LOAD_A, r, c, v);
                if ($urandom_range(15) == 0)
                    send_cmd(MODE_UNUSED, $urandom, $urandom, $urandom);
            end
        end
        for (int r = 0; r < n; r++) begin
            v = (shape == SYS_WILD) ? $urandom : $signed($urandom_range(1048575)) - 524288;
            send_cmd(MODE_LOAD_B, r, $urandom, v);
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        int          n;
        int          solve_no;
        logic [30:0] tl;
        logic [15:0] mi;
        sys_shape_t  shape;
        @(posedge rst_n);
        @(posedge clk);

        // size zero acts as one; extreme element values
        write_regs(32'd0, 32'd65, 32'd100);
        send_cmd(MODE_LOAD_A, 0, 0, 32'h7FFF_FFFF);
        send_cmd(MODE_LOAD_B, 0, 0, 32'h8000_0000);
        send_cmd(MODE_START, 0, 0, 0);
        // repeated solve sees the normalized, zero diagonal
        send_cmd(MODE_START, 0, 0, 0);
        send_cmd(MODE_UNUSED, 15, 15, 32'hFFFF_FFFF);
        wait_idle();

        // zero tolerance: zero diagonal still fails, otherwise run to the limit
        write_regs(32'hFFFF_FFE1, 32'h8000_0000, 32'd5);
        send_cmd(MODE_LOAD_A, 0, 0, 32'd0);
        send_cmd(MODE_LOAD_B, 0, 0, 32'd65536);
        send_cmd(MODE_START, 0, 0, 0);
        send_cmd(MODE_LOAD_A, 0, 0, 32'h8000_0000);
        send_cmd(MODE_START, 0, 0, 0);
        wait_idle();

        // widest tolerance: the most negative diagonal passes, a smaller magnitude fails
        write_regs(32'd1, 32'h7FFF_FFFF, 32'd100);
        send_cmd(MODE_LOAD_A, 0, 0, 32'h8000_0000);
        send_cmd(MODE_LOAD_B, 0, 0, 32'h7FFF_FFFF);
        send_cmd(MODE_START, 0, 0, 0);
        send_cmd(MODE_LOAD_A, 0, 0, 32'h7FFF_FFFE);
        send_cmd(MODE_START, 0, 0, 0);
        wait_idle();

        // max iterations zero acts as one sweep
        write_regs(32'd1, 32'd70, 32'hFFFF_0000);
        send_cmd(MODE_LOAD_A, 0, 0, 32'd131072);
        send_cmd(MODE_LOAD_B, 0, 0, 32'd327680);
        send_cmd(MODE_START, 0, 0, 0);
        wait_idle();
        write_regs(32'd1, 32'd70, 32'hFFFF);
        send_cmd(MODE_LOAD_A, 0, 0, 32'd131072);
        send_cmd(MODE_START, 0, 0, 0);

        solve_no = 0;
        while (items_sent < ITEM_TARGET) begin
            wait_idle();
            quiet = (solve_no >= 2 && solve_no < 5);
            n = ($urandom_range(7) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
            case ($urandom_range(19))
                0, 1, 2: shape = SYS_WEAK_DIAG;
                3, 4, 5: shape = SYS_WILD;
                default: shape = SYS_DOMINANT;
            endcase
            case ($urandom_range(9))
                0:       tl = 31'd0;
                1:       tl = 31'($urandom_range(16, 4096));
                2:       tl = 31'($urandom);
                default: tl = 31'd65;
            endcase
            mi = 16'($urandom_range(1, 150));
            if ($urandom_range(7) == 0)
                mi = 16'd0;
            else if (shape == SYS_DOMINANT && tl >= 16 && $urandom_range(5) == 0)
                mi = 16'hFFFF;
            write_regs(32'({$urandom_range(255), 5'(n)}), 32'({$urandom_range(1), tl}),
                       32'({$urandom_range(65535), mi}));
            load_system(n, shape);
            send_cmd(MODE_START, $urandom, $urandom, $urandom);
            if ($urandom_range(5) == 0)
                send_cmd(MODE_START, $urandom, $urandom, $urandom);
            solve_no++;
        end
        quiet = 1'b0;
        wait_idle();
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #(20_000_000);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

### files.f
sv/gs_pkg.sv
sv/gs_front.sv
sv/gs_divider.sv
sv/gs_engine.sv
sv/gauss_seidel_solver.sv
sv/gs_checker.sv
tb/tb_gauss_seidel_solver.sv
